[src/rcle_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rotor cipher letter engine package
// Shared types, rotor and reflector tables, mod-26 helpers.
// ----------------------------------------------------------------------------
package rcle_pkg;

	localparam int unsigned PIPE_STAGES = 7;

	localparam logic [4:0] LAST_LETTER = 5'd25;
	localparam logic [7:0] CHAR_A      = 8'h41;
	localparam logic [7:0] CHAR_Z      = 8'h5A;

	localparam logic [2:0] REG_ROTOR_ORDER = 3'd0;
	localparam logic [2:0] REG_RING        = 3'd1;
	localparam logic [2:0] REG_START       = 3'd2;
	localparam logic [2:0] REG_PLUG_LOW    = 3'd3;
	localparam logic [2:0] REG_PLUG_MID    = 3'd4;
	localparam logic [2:0] REG_PLUG_HIGH   = 3'd5;

	localparam logic [2:0] SLOT_LEFT   = 3'd0;
	localparam logic [2:0] SLOT_MIDDLE = 3'd1;
	localparam logic [2:0] SLOT_RIGHT  = 3'd2;

	typedef logic [4:0][25:0][4:0] wire_tab_t;
	typedef logic [25:0][4:0]      plug_tab_t;

	typedef enum logic [1:0] {
		ITEM_PASS,
		ITEM_LETTER,
		ITEM_REWIND
	} item_kind_t;

	typedef struct packed {
		logic [2:0][2:0] kind;   // normalised rotor kind 0..4, slot 0 left
		logic [2:0][4:0] ring;   // ring offset 0..25
		logic [2:0][4:0] start;  // start position 0..25
		plug_tab_t       plug;   // raw partner per letter
	} cfg_t;

	typedef struct packed {
		item_kind_t      kind;
		logic [7:0]      raw;
		logic [4:0]      sym;
		logic [2:0][4:0] pos;
	} item_t;

	localparam logic [4:0][207:0] WIRE_STR = {
		"VZBRGITYUPSDNHLXAWMJQOFECK",
		"ESOVPZJAYQUIRHXLNFTGKDCMWB",
		"BDFHJLCPRTXVZNYEIWGAKMUSQO",
		"AJDKSIRUXBLHWTMCQGZNPYFVOE",
		"EKMFLGDQVZNTOWYHXUSPAIBRCJ"
	};
	localparam logic [207:0] REFL_STR = "YRUHQSLDPXNGOKMIEBFZCWVJAT";

	// notches Q E V J Z
	localparam logic [4:0][4:0] NOTCH = {5'd25, 5'd9, 5'd21, 5'd4, 5'd16};

	function automatic wire_tab_t build_fwd();
		wire_tab_t t;
		int k;
		int i;
		t = '0;
		for (k = 0; k < 5; k++) begin
			for (i = 0; i < 26; i++) begin
				t[k][i] = 5'(WIRE_STR[k][8*(25-i) +: 8] - CHAR_A);
			end
		end
		return t;
	endfunction

	function automatic wire_tab_t build_inv();
		wire_tab_t f;
		wire_tab_t t;
		int k;
		int i;
		f = build_fwd();
		t = '0;
		for (k = 0; k < 5; k++) begin
			for (i = 0; i < 26; i++) begin
				t[k][f[k][i]] = 5'(i);
			end
		end
		return t;
	endfunction

	function automatic plug_tab_t build_refl();
		plug_tab_t t;
		int i;
		t = '0;
		for (i = 0; i < 26; i++) begin
			t[i] = 5'(REFL_STR[8*(25-i) +: 8] - CHAR_A);
		end
		return t;
	endfunction

	localparam wire_tab_t FWD_TAB  = build_fwd();
	localparam wire_tab_t INV_TAB  = build_inv();
	localparam plug_tab_t REFL_TAB = build_refl();

	function automatic logic [4:0] fix26(input logic [4:0] v);
		return (v > LAST_LETTER) ? 5'(v - 5'd26) : v;
	endfunction

	function automatic logic [4:0] add26(input logic [4:0] a, input logic [4:0] b);
		logic [5:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s > {1'b0, LAST_LETTER}) ? 5'(s - 6'd26) : s[4:0];
	endfunction

	function automatic logic [4:0] sub26(input logic [4:0] a, input logic [4:0] b);
		return (a >= b) ? 5'(a - b) : 5'(a + 5'd26 - b);
	endfunction

	function automatic logic [4:0] inc26(input logic [4:0] p);
		return (p == LAST_LETTER) ? 5'd0 : 5'(p + 5'd1);
	endfunction

	function automatic logic [4:0] rotor_fwd(input logic [4:0] sym, input logic [4:0] pos,
			input logic [4:0] ring, input logic [2:0] kind);
		logic [4:0] sh;
		sh = sub26(pos, ring);
		return sub26(FWD_TAB[kind][add26(sym, sh)], sh);
	endfunction

	function automatic logic [4:0] rotor_bwd(input logic [4:0] sym, input logic [4:0] pos,
			input logic [4:0] ring, input logic [2:0] kind);
		logic [4:0] sh;
		sh = sub26(pos, ring);
		return sub26(INV_TAB[kind][add26(sym, sh)], sh);
	endfunction

	function automatic logic [4:0] plug_pass(input logic [4:0] sym, input plug_tab_t pm);
		logic [4:0] p;
		p = pm[sym];
		return (p > LAST_LETTER) ? sym : p;
	endfunction

endpackage
`default_nettype wire

[src/rotor_cipher_letter_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rotor cipher letter engine
// Three-rotor letter cipher with reflector B, plugboard and rewind.
// ----------------------------------------------------------------------------
// Path: a request accepted is written to the queue, then passes the seven
//   cipher stages before its result shows on m_tvalid.
// Throughput: one request per cycle while the queue is not full; the rotor
//   stepping is one mod-26 update per accepted request in the front part.
// Reset: arst_n clears rotor positions, queue and pipeline valids; registers
//   return to rotor order 80 and zero elsewhere.
module rotor_cipher_letter_engine #(
	parameter int unsigned FIFO_DEPTH = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] in_byte
	input  wire  [0:0]  s_tuser,   // [0] op
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [12:8] left_pos,
	                               // [17:13] middle_pos, [22:18] right_pos, [23] zero
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [59:0] cfg_data
);
	import rcle_pkg::*;

	logic [8:0]      rotor_order_q;
	logic [14:0]     ring_q;
	logic [14:0]     start_q;
	logic [59:0]     plug_low_q;
	logic [59:0]     plug_mid_q;
	logic [9:0]      plug_high_q;
	cfg_t            cfg;
	logic            push;
	item_t           push_item;
	logic            fifo_full;
	logic            pop_valid;
	logic            pop;
	item_t           pop_item;
	logic [7:0]      out_byte;
	logic [2:0][4:0] out_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotor_order_q <= 9'd80;
			ring_q        <= '0;
			start_q       <= '0;
			plug_low_q    <= '0;
			plug_mid_q    <= '0;
			plug_high_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROTOR_ORDER: rotor_order_q <= cfg_data[8:0];
				REG_RING:        ring_q        <= cfg_data[14:0];
				REG_START:       start_q       <= cfg_data[14:0];
				REG_PLUG_LOW:    plug_low_q    <= cfg_data;
				REG_PLUG_MID:    plug_mid_q    <= cfg_data;
				REG_PLUG_HIGH:   plug_high_q   <= cfg_data[9:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		for (int s = 0; s < 3; s++) begin
			cfg.kind[s]  = (rotor_order_q[3*s +: 3] > 3'd4) ? 3'd0 : rotor_order_q[3*s +: 3];
			cfg.ring[s]  = fix26(ring_q[5*s +: 5]);
			cfg.start[s] = fix26(start_q[5*s +: 5]);
		end
		for (int i = 0; i < 12; i++) begin
			cfg.plug[i]      = plug_low_q[5*i +: 5];
			cfg.plug[12 + i] = plug_mid_q[5*i +: 5];
		end
		cfg.plug[24] = plug_high_q[4:0];
		cfg.plug[25] = plug_high_q[9:5];
	end

	rcle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser[0]),
		.in_byte   (s_tdata),
		.full      (fifo_full),
		.push      (push),
		.push_item (push_item)
	);

	rcle_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (fifo_full),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_item  (pop_item)
	);

	rcle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (pop_valid),
		.in_ready  (pop),
		.in_item   (pop_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (out_byte),
		.out_pos   (out_pos)
	);

	assign m_tdata = {1'b0, out_pos[SLOT_RIGHT], out_pos[SLOT_MIDDLE], out_pos[SLOT_LEFT],
		out_byte};

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_full)
		else $error("queue written while full");

	a_rewind_loads_start: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_item.kind == ITEM_REWIND) |-> (push_item.pos == cfg.start))
		else $error("rewind did not load start positions");

	a_out_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_pos[SLOT_LEFT] < 5'd26 && out_pos[SLOT_MIDDLE] < 5'd26
			&& out_pos[SLOT_RIGHT] < 5'd26))
		else $error("rotor position out of range");
`endif

endmodule
`default_nettype wire

[src/rcle_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module rcle_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  rcle_pkg::item_t push_item,
	output logic            full,
	output logic            pop_valid,
	input  wire             pop,
	output rcle_pkg::item_t pop_item
);
	import rcle_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t            slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign do_pop    = pop && pop_valid;
	assign pop_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop) rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !do_pop) cnt_q <= CNT_W'(cnt_q + 1'b1);
			else if (do_pop && !push) cnt_q <= CNT_W'(cnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

[src/rcle_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front part
// Accept requests, classify them and step or rewind the rotor positions.
// ----------------------------------------------------------------------------
module rcle_front (
	input  wire             clk,
	input  wire             arst_n,
	input  rcle_pkg::cfg_t  cfg,
	input  wire             in_valid,
	output logic            in_ready,
	input  wire             in_op,
	input  wire  [7:0]      in_byte,
	input  wire             full,
	output logic            push,
	output rcle_pkg::item_t push_item
);
	import rcle_pkg::*;

	logic [2:0][4:0] pos_q;
	logic [2:0][4:0] stepped;
	logic            is_letter;
	logic            mid_notch;
	logic            right_notch;

	assign in_ready  = !full;
	assign push      = in_valid && !full;
	assign is_letter = (in_byte >= CHAR_A) && (in_byte <= CHAR_Z);

	assign mid_notch   = (pos_q[SLOT_MIDDLE] == NOTCH[cfg.kind[SLOT_MIDDLE]]);
	assign right_notch = (pos_q[SLOT_RIGHT] == NOTCH[cfg.kind[SLOT_RIGHT]]);

	always_comb begin
		stepped             = pos_q;
		stepped[SLOT_RIGHT] = inc26(pos_q[SLOT_RIGHT]);
		if (mid_notch) begin
			stepped[SLOT_LEFT]   = inc26(pos_q[SLOT_LEFT]);
			stepped[SLOT_MIDDLE] = inc26(pos_q[SLOT_MIDDLE]);
		end else if (right_notch) begin
			stepped[SLOT_MIDDLE] = inc26(pos_q[SLOT_MIDDLE]);
		end
	end

	always_comb begin
		push_item.raw = in_byte;
		push_item.sym = 5'(in_byte - CHAR_A);
		if (in_op) begin
			push_item.kind = ITEM_REWIND;
			push_item.pos  = cfg.start;
		end else if (is_letter) begin
			push_item.kind = ITEM_LETTER;
			push_item.pos  = stepped;
		end else begin
			push_item.kind = ITEM_PASS;
			push_item.pos  = pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= push_item.pos;
		end
	end

endmodule
`default_nettype wire

[src/rcle_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Back part
// Seven-stage cipher pipeline: plugboard, rotors in, reflector, rotors out,
// plugboard, with per-stage stall.
// ----------------------------------------------------------------------------
module rcle_back (
	input  wire             clk,
	input  wire             arst_n,
	input  rcle_pkg::cfg_t  cfg,
	input  wire             in_valid,
	output logic            in_ready,
	input  rcle_pkg::item_t in_item,
	output logic            out_valid,
	input  wire             out_ready,
	output logic [7:0]      out_byte,
	output logic [2:0][4:0] out_pos
);
	import rcle_pkg::*;

	localparam int unsigned LAST = PIPE_STAGES - 1;

	item_t      rec_q   [PIPE_STAGES];
	logic       vld_q   [PIPE_STAGES];
	logic       rdy     [PIPE_STAGES+1];
	item_t      stg_in  [PIPE_STAGES];
	item_t      stg_out [PIPE_STAGES];
	logic       stg_vld [PIPE_STAGES];
	logic [4:0] stg_sym [PIPE_STAGES];

	assign rdy[PIPE_STAGES] = out_ready;
	assign in_ready         = rdy[0];

	for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_stg
		if (k == 0) begin : g_first
			assign stg_in[k]  = in_item;
			assign stg_vld[k] = in_valid;
		end else begin : g_next
			assign stg_in[k]  = rec_q[k-1];
			assign stg_vld[k] = vld_q[k-1];
		end

		assign rdy[k] = !vld_q[k] || rdy[k+1];

		if (k == 0) begin : g_plug_in
			assign stg_sym[k] = plug_pass(stg_in[k].sym, cfg.plug);
		end else if (k == 1) begin : g_fwd_right
			assign stg_sym[k] = rotor_fwd(stg_in[k].sym, stg_in[k].pos[SLOT_RIGHT],
				cfg.ring[SLOT_RIGHT], cfg.kind[SLOT_RIGHT]);
		end else if (k == 2) begin : g_fwd_mid
			assign stg_sym[k] = rotor_fwd(stg_in[k].sym, stg_in[k].pos[SLOT_MIDDLE],
				cfg.ring[SLOT_MIDDLE], cfg.kind[SLOT_MIDDLE]);
		end else if (k == 3) begin : g_fwd_left
			assign stg_sym[k] = REFL_TAB[rotor_fwd(stg_in[k].sym, stg_in[k].pos[SLOT_LEFT],
				cfg.ring[SLOT_LEFT], cfg.kind[SLOT_LEFT])];
		end else if (k == 4) begin : g_bwd_left
			assign stg_sym[k] = rotor_bwd(stg_in[k].sym, stg_in[k].pos[SLOT_LEFT],
				cfg.ring[SLOT_LEFT], cfg.kind[SLOT_LEFT]);
		end else if (k == 5) begin : g_bwd_mid
			assign stg_sym[k] = rotor_bwd(stg_in[k].sym, stg_in[k].pos[SLOT_MIDDLE],
				cfg.ring[SLOT_MIDDLE], cfg.kind[SLOT_MIDDLE]);
		end else begin : g_bwd_right
			assign stg_sym[k] = plug_pass(rotor_bwd(stg_in[k].sym, stg_in[k].pos[SLOT_RIGHT],
				cfg.ring[SLOT_RIGHT], cfg.kind[SLOT_RIGHT]), cfg.plug);
		end

		assign stg_out[k] = '{kind: stg_in[k].kind, raw: stg_in[k].raw, sym: stg_sym[k],
			pos: stg_in[k].pos};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_q[k] <= stg_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && stg_vld[k]) begin
				rec_q[k] <= stg_out[k];
			end
		end
	end

	assign out_valid = vld_q[LAST];
	assign out_pos   = rec_q[LAST].pos;

	always_comb begin
		case (rec_q[LAST].kind)
			ITEM_LETTER: out_byte = CHAR_A + {3'b000, rec_q[LAST].sym};
			ITEM_REWIND: out_byte = 8'h00;
			default:     out_byte = rec_q[LAST].raw;
		endcase
	end

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotor cipher letter engine testbench
// Drives cipher and rewind requests through the stream input under random
// bursts and output stalls. Each result is checked against a typed table value
// or an in-bench rotor machine model: stepping with double step, plugboard,
// rotors and reflector B. A directed table of extremes comes first, then random
// register settings with mostly letter traffic, often started near the rotor notches.
// ----------------------------------------------------------------------------
module tb_top;
	import rcle_pkg::*;

	localparam logic OP_ENCIPHER = 1'b0;
	localparam logic OP_REWIND   = 1'b1;

	localparam logic [207:0] WIRE_I   = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
	localparam logic [207:0] WIRE_II  = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
	localparam logic [207:0] WIRE_III = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
	localparam logic [207:0] WIRE_IV  = "ESOVPZJAYQUIRHXLNFTGKDCMWB";
	localparam logic [207:0] WIRE_V   = "VZBRGITYUPSDNHLXAWMJQOFECK";
	localparam logic [207:0] REFLECTOR_B   = "YRUHQSLDPXNGOKMIEBFZCWVJAT";
	localparam logic [39:0]  NOTCH_LETTERS = "QEVJZ";

	localparam int RANDOM_PHASES    = 9;
	localparam int ITEMS_PER_PHASE  = 150;

	typedef enum logic {
		ROW_REQUEST,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [59:0] val;
		logic        op;
		logic [7:0]  in_char;
		logic        known;
		logic [23:0] res;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 44;

	directed_row_t directed_tab [DIRECTED_ROWS] = '{
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, 8'h00, 1'b1, 24'h000000},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, 8'hFF, 1'b1, 24'h0000FF},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, 8'h40, 1'b1, 24'h000040},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, 8'h5B, 1'b1, 24'h00005B},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, 8'h61, 1'b1, 24'h000061},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, "A", 1'b0, '0},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, "Z", 1'b0, '0},
		'{ROW_REQUEST, '0, '0, OP_REWIND, 8'hFF, 1'b1, 24'h000000},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, "M", 1'b0, '0},
		'{ROW_WRITE, REG_ROTOR_ORDER, 60'd136, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_WRITE, REG_RING, 60'd0, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_WRITE, REG_START, 60'd21600, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_WRITE, REG_PLUG_LOW, 60'hFFF_FFFF_FFFF_FFF9, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_WRITE, REG_PLUG_MID, 60'hFFF_FFFF_FFFF_FFFF, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_WRITE, REG_PLUG_HIGH, 60'h01F, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_REQUEST, '0, '0, OP_REWIND, 8'h00, 1'b1, {1'b0, 5'd21, 5'd3, 5'd0, 8'h00}},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, "A", 1'b0, '0},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, "A", 1'b0, '0},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, "Z", 1'b0, '0},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, 8'h20, 1'b0, '0},
		'{ROW_WRITE, REG_ROTOR_ORDER, 60'd231, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_WRITE, REG_RING, 60'd26463, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_WRITE, REG_START, 60'd28606, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_WRITE, REG_PLUG_MID, 60'h123_4567_89AB_CDEF, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_REQUEST, '0, '0, OP_REWIND, 8'h41, 1'b1, {1'b0, 5'd1, 5'd3, 5'd4, 8'h00}},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, "Q", 1'b0, '0},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, "E", 1'b0, '0},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, "V", 1'b0, '0},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, "J", 1'b0, '0},
		'{ROW_WRITE, REG_ROTOR_ORDER, 60'd511, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_WRITE, REG_RING, 60'd32767, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_WRITE, REG_START, 60'd0, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_REQUEST, '0, '0, OP_REWIND, 8'h00, 1'b1, 24'h000000},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, "A", 1'b0, '0},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, 8'h80, 1'b0, '0},
		'{ROW_WRITE, REG_ROTOR_ORDER, 60'd0, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_WRITE, REG_RING, 60'd0, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_WRITE, REG_START, 60'd32767, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_WRITE, REG_PLUG_LOW, 60'hFFF_FFFF_FFFF_FFFF, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_WRITE, REG_PLUG_MID, 60'd0, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_WRITE, REG_PLUG_HIGH, 60'h3FF, OP_ENCIPHER, '0, 1'b0, '0},
		'{ROW_REQUEST, '0, '0, OP_REWIND, 8'h00, 1'b1, {1'b0, 5'd5, 5'd5, 5'd5, 8'h00}},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, "B", 1'b0, '0},
		'{ROW_REQUEST, '0, '0, OP_ENCIPHER, "Y", 1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] in_byte
	logic [0:0]  s_tuser = '0;   // [0] op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // [7:0] out_byte, [12:8] left, [17:13] middle, [22:18] right
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [59:0] cfg_data = '0;

	// model copy of the registers and rotor positions
	logic [8:0]  order_r = 9'd80;
	logic [14:0] ring_r = '0;
	logic [14:0] start_r = '0;
	logic [59:0] plug_lo = '0;
	logic [59:0] plug_md = '0;
	logic [9:0]  plug_hi = '0;
	logic [4:0]  rotor_pos [3] = '{5'd0, 5'd0, 5'd0};

	logic [23:0] pending_results [$];
	logic [23:0] want_word;
	int          mismatch_count = 0;
	int          results_seen = 0;
	int          letter_count = 0;
	int          rewind_count = 0;
	int          pass_count = 0;
	int          write_count = 0;
	int          burst_left = 0;
	int unsigned rx_cycle = 0;

	rotor_cipher_letter_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int rotor_kind(int slot);
		int code;
		code = int'(order_r[3*slot +: 3]);
		return (code > 4) ? 0 : code;
	endfunction

	function automatic int notch_of(int kind);
		return int'(NOTCH_LETTERS[8*(4-kind) +: 8]) - int'(CHAR_A);
	endfunction

	function automatic int wiring_sym(int kind, int idx);
		logic [207:0] w;
		case (kind)
			1: w = WIRE_II;
			2: w = WIRE_III;
			3: w = WIRE_IV;
			4: w = WIRE_V;
			default: w = WIRE_I;
		endcase
		return int'(w[8*(25-idx) +: 8]) - int'(CHAR_A);
	endfunction

	function automatic int through_rotor(int slot, int c, bit back);
		int sh;
		int k;
		int j;
		int found;
		sh = (int'(rotor_pos[slot]) + 26 - int'(ring_r[5*slot +: 5]) % 26) % 26;
		k = rotor_kind(slot);
		if (!back)
			return (wiring_sym(k, (c + sh) % 26) + 26 - sh) % 26;
		found = 0;
		for (j = 0; j < 26; j++)
			if (wiring_sym(k, j) == (c + sh) % 26)
				found = j;
		return (found + 26 - sh) % 26;
	endfunction

	function automatic int plug_sym(int c);
		logic [4:0] p;
		if (c < 12)
			p = plug_lo[5*c +: 5];
		else if (c < 24)
			p = plug_md[5*(c-12) +: 5];
		else
			p = plug_hi[5*(c-24) +: 5];
		return (p > LAST_LETTER) ? c : int'(p);
	endfunction

	function automatic void advance_rotor(int slot);
		rotor_pos[slot] = (rotor_pos[slot] == LAST_LETTER) ? 5'd0 : rotor_pos[slot] + 5'd1;
	endfunction

	function automatic bit at_notch(int slot);
		return int'(rotor_pos[slot]) == notch_of(rotor_kind(slot));
	endfunction

	function automatic logic [23:0] encipher_request(logic op, logic [7:0] ch);
		int s;
		int i;
		bit mid_notch;
		bit right_notch;
		logic [7:0] o;
		if (op == OP_REWIND) begin
			for (i = 0; i < 3; i++)
				rotor_pos[i] = 5'(int'(start_r[5*i +: 5]) % 26);
			o = 8'h00;
		end else if (ch < CHAR_A || ch > CHAR_Z) begin
			o = ch;
		end else begin
			mid_notch = at_notch(1);
			right_notch = at_notch(2);
			if (mid_notch) begin
				advance_rotor(0);
				advance_rotor(1);
			end else if (right_notch) begin
				advance_rotor(1);
			end
			advance_rotor(2);
			s = plug_sym(int'(ch - CHAR_A));
			s = through_rotor(2, s, 1'b0);
			s = through_rotor(1, s, 1'b0);
			s = through_rotor(0, s, 1'b0);
			s = int'(REFLECTOR_B[8*(25-s) +: 8]) - int'(CHAR_A);
			s = through_rotor(0, s, 1'b1);
			s = through_rotor(1, s, 1'b1);
			s = through_rotor(2, s, 1'b1);
			s = plug_sym(s);
			o = 8'(int'(CHAR_A) + s);
		end
		return {1'b0, rotor_pos[2], rotor_pos[1], rotor_pos[0], o};
	endfunction

	function automatic logic [59:0] pick_value(logic [59:0] all_ones);
		int r;
		r = $urandom_range(0, 4);
		if (r == 0)
			return '0;
		if (r == 1)
			return all_ones;
		return 60'({$urandom, $urandom}) & all_ones;
	endfunction

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [59:0] val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_ROTOR_ORDER: order_r = val[8:0];
			REG_RING:        ring_r = val[14:0];
			REG_START:       start_r = val[14:0];
			REG_PLUG_LOW:    plug_lo = val;
			REG_PLUG_MID:    plug_md = val;
			REG_PLUG_HIGH:   plug_hi = val[9:0];
			default: ;
		endcase
		write_count++;
	endtask

	task automatic send_request(input logic op, input logic [7:0] ch, input logic known,
			input logic [23:0] typed);
		logic [23:0] predicted;
		int gap;
		cfg_we <= 1'b0;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= ch;
		do
			@(posedge clk);
		while (!s_tready);
		predicted = encipher_request(op, ch);
		pending_results.push_back(known ? typed : predicted);
		if (op == OP_REWIND)
			rewind_count++;
		else if (ch < CHAR_A || ch > CHAR_Z)
			pass_count++;
		else
			letter_count++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_random_plugs();
		logic [4:0]  partner [26];
		int          perm [26];
		int          i;
		int          j;
		int          t;
		int          pairs;
		logic [59:0] lo;
		logic [59:0] md;
		logic [9:0]  hi;
		for (i = 0; i < 26; i++)
			perm[i] = i;
		for (i = 25; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (i = 0; i < 26; i++)
			partner[i] = $urandom_range(0, 1) ? 5'(i) : 5'($urandom_range(26, 31));
		pairs = $urandom_range(0, 13);
		for (i = 0; i < pairs; i++) begin
			partner[perm[2*i]] = 5'(perm[2*i+1]);
			partner[perm[2*i+1]] = 5'(perm[2*i]);
		end
		lo = '0;
		md = '0;
		hi = '0;
		for (i = 0; i < 12; i++) begin
			lo[5*i +: 5] = partner[i];
			md[5*i +: 5] = partner[12+i];
		end
		hi = {partner[25], partner[24]};
		// raw maps that are not pairs, now and then
		if ($urandom_range(0, 9) >= 7) begin
			lo = pick_value(60'hFFF_FFFF_FFFF_FFFF);
			md = pick_value(60'hFFF_FFFF_FFFF_FFFF);
			hi = 10'(pick_value(60'h3FF));
		end
		write_reg(REG_PLUG_LOW, lo);
		write_reg(REG_PLUG_MID, md);
		write_reg(REG_PLUG_HIGH, 60'(hi));
	endtask

	task automatic random_phase(input int n_items);
		int          k;
		int          r;
		logic [14:0] start_v;
		logic [7:0]  edge_chars [4];
		edge_chars = '{8'h40, 8'h41, 8'h5A, 8'h5B};
		write_reg(REG_ROTOR_ORDER, pick_value(60'h1FF));
		write_reg(REG_RING, pick_value(60'h7FFF));
		// start near the notches so that the double step comes up often
		if ($urandom_range(0, 1)) begin
			start_v = {5'((notch_of(rotor_kind(2)) + 26 - $urandom_range(0, 3)) % 26),
				5'((notch_of(rotor_kind(1)) + 26 - $urandom_range(0, 1)) % 26),
				5'($urandom_range(0, 31))};
			write_reg(REG_START, 60'(start_v));
		end else begin
			write_reg(REG_START, pick_value(60'h7FFF));
		end
		write_random_plugs();
		if ($urandom_range(0, 1))
			send_request(OP_REWIND, 8'($urandom), 1'b0, '0);
		for (k = 0; k < n_items; k++) begin
			r = $urandom_range(0, 99);
			if (r < 72)
				send_request(OP_ENCIPHER, 8'(int'(CHAR_A) + $urandom_range(0, 25)), 1'b0, '0);
			else if (r < 88)
				send_request(OP_ENCIPHER, 8'($urandom), 1'b0, '0);
			else if (r < 93)
				send_request(OP_REWIND, 8'($urandom), 1'b0, '0);
			else
				send_request(OP_ENCIPHER, edge_chars[$urandom_range(0, 3)], 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result %h at %0t", m_tdata, $realtime);
				mismatch_count++;
			end else begin
				want_word = pending_results.pop_front();
				if (m_tdata[7:0] !== want_word[7:0] || m_tdata[12:8] !== want_word[12:8] ||
						m_tdata[17:13] !== want_word[17:13] ||
						m_tdata[22:18] !== want_word[22:18] || m_tdata[23] !== want_word[23]) begin
					if (mismatch_count < 10)
						$display("result %0d: expected byte %h pos %0d/%0d/%0d pad %b, got byte %h pos %0d/%0d/%0d pad %b",
							results_seen, want_word[7:0], want_word[12:8], want_word[17:13],
							want_word[22:18], want_word[23], m_tdata[7:0], m_tdata[12:8],
							m_tdata[17:13], m_tdata[22:18], m_tdata[23]);
					mismatch_count++;
				end
			end
		end
		rx_cycle <= rx_cycle + 1;
		case (rx_cycle[10:9])
			2'd0: m_tready <= 1'b1;
			2'd1: m_tready <= ($urandom_range(0, 9) < 7);
			2'd2: m_tready <= (rx_cycle[1:0] == 2'd0);
			default: m_tready <= rx_cycle[3];
		endcase
	end

	initial begin
		int row;
		int phase;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (row = 0; row < DIRECTED_ROWS; row++) begin
			if (directed_tab[row].kind == ROW_WRITE)
				write_reg(directed_tab[row].idx, directed_tab[row].val);
			else
				send_request(directed_tab[row].op, directed_tab[row].in_char,
					directed_tab[row].known, directed_tab[row].res);
		end
		for (phase = 0; phase < RANDOM_PHASES; phase++)
			random_phase(ITEMS_PER_PHASE);
		drain_results();
		repeat (4 * PIPE_STAGES) @(posedge clk);
		$display("covered %0d letters, %0d rewinds, %0d pass-through bytes, %0d register writes",
			letter_count, rewind_count, pass_count, write_count);
		$display("checked %0d results, %0d mismatching", results_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout: %0d results still outstanding", pending_results.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
